// ----- sv/sfd_pkg.sv -----
// Shared types and constants for the sensor frame deframer
package sfd_pkg;

	// Payload store depth and derived widths
	localparam int MaxPayload = 32;
	localparam int IdxW       = $clog2(MaxPayload);
	localparam int CntW       = $clog2(MaxPayload + 1);

	// Request kinds
	localparam logic ReqByte = 1'b0;
	localparam logic ReqTick = 1'b1;

	// Result status codes
	localparam logic [2:0] StOk       = 3'd0;
	localparam logic [2:0] StBadTail  = 3'd1;
	localparam logic [2:0] StTooLong  = 3'd2;
	localparam logic [2:0] StBadSum   = 3'd3;
	localparam logic [2:0] StLinkLost = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] RegHeaderFirst  = 3'd0;
	localparam logic [2:0] RegHeaderSecond = 3'd1;
	localparam logic [2:0] RegTailFirst    = 3'd2;
	localparam logic [2:0] RegTailSecond   = 3'd3;
	localparam logic [2:0] RegLinkTimeout  = 3'd4;

	// Configuration reset values
	localparam logic [7:0]  RstHeaderFirst  = 8'd83;
	localparam logic [7:0]  RstHeaderSecond = 8'd89;
	localparam logic [7:0]  RstTailFirst    = 8'd84;
	localparam logic [7:0]  RstTailSecond   = 8'd67;
	localparam logic [15:0] RstLinkTimeout  = 16'd2000;

	// Input request
	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} req_t;

	// Output result
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  control_code;
		logic [7:0]  command_code;
		logic [15:0] payload_length;
		logic [4:0]  byte_index;
		logic [7:0]  payload_byte;
		logic        last;
		logic        link_up;
	} rsp_t;

	// Live configuration values
	typedef struct packed {
		logic [7:0]  header_first;
		logic [7:0]  header_second;
		logic [7:0]  tail_first;
		logic [7:0]  tail_second;
		logic [15:0] link_timeout_ms;
	} cfg_t;

	// Payload store write port
	typedef struct packed {
		logic            en;
		logic [IdxW-1:0] addr;
		logic [7:0]      data;
	} wr_t;

	// Result run launch from parser to emitter; cnt of zero means a single
	// result with no payload byte
	typedef struct packed {
		logic            valid;
		logic [2:0]      status;
		logic [7:0]      control;
		logic [7:0]      command;
		logic [15:0]     length;
		logic            link_up;
		logic [CntW-1:0] cnt;
	} start_t;

endpackage

// ----- sv/sfd_parser.sv -----
// Frame parser: header hunt, field capture, running sum, tail check, link timer
module sfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  sfd_pkg::req_t     req,
	input  sfd_pkg::cfg_t     cfg,
	output sfd_pkg::wr_t      wr,
	output sfd_pkg::start_t   start
);

	logic        in_frame_q, in_frame_d;
	logic [16:0] count_q, count_d;
	logic [7:0]  ctrl_q, ctrl_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  sum_q, sum_d;
	logic        sum_ok_q, sum_ok_d;
	logic        tail_ok_q, tail_ok_d;
	logic        link_q, link_d;
	logic [15:0] idle_q, idle_d;

	logic [7:0]  b;
	logic [7:0]  sum_add;
	logic [16:0] rel;
	logic [16:0] len17;
	logic [16:0] len_p1;
	logic [15:0] idle_inc;
	logic        tail_good;

	assign b        = req.rx_byte;
	// Shared 8-bit adder for the running checksum
	assign sum_add  = sum_q + b;
	assign rel      = count_q - 17'd6;
	assign len17    = {1'b0, len_q};
	assign len_p1   = len17 + 17'd1;
	assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
	assign tail_good = tail_ok_q && (b == cfg.tail_second);

	// Next state and result launch
	always_comb begin
		in_frame_d = in_frame_q;
		count_d    = count_q;
		ctrl_d     = ctrl_q;
		cmd_d      = cmd_q;
		len_d      = len_q;
		sum_d      = sum_q;
		sum_ok_d   = sum_ok_q;
		tail_ok_d  = tail_ok_q;
		link_d     = link_q;
		idle_d     = idle_q;
		wr         = '0;
		start      = '0;
		start.control = ctrl_q;
		start.command = cmd_q;
		start.length  = len_q;
		if (fire && req.req_type == sfd_pkg::ReqByte) begin
			idle_d  = '0;
			link_d  = 1'b1;
			start.link_up = 1'b1;
			if (!in_frame_q) begin
				// hunting for the first header byte
				if (b == cfg.header_first) begin
					in_frame_d = 1'b1;
					count_d    = 17'd1;
					sum_d      = b;
				end
			end else begin
				count_d = count_q + 17'd1;
				if (count_q == 17'd1) begin
					if (b != cfg.header_second) begin
						in_frame_d = 1'b0;
						count_d    = '0;
					end else begin
						sum_d = sum_add;
					end
				end else if (count_q < 17'd6) begin
					sum_d = sum_add;
					case (count_q[2:0])
						3'd2:    ctrl_d = b;
						3'd3:    cmd_d  = b;
						3'd4:    len_d  = {b, 8'h00};
						default: len_d  = {len_q[15:8], b};
					endcase
				end else if (rel < len17) begin
					// payload byte; beyond the store it is only summed
					sum_d = sum_add;
					if (rel < 17'(sfd_pkg::MaxPayload)) begin
						wr.en   = 1'b1;
						wr.addr = rel[sfd_pkg::IdxW-1:0];
						wr.data = b;
					end
				end else if (rel == len17) begin
					sum_ok_d = (b == sum_q);
				end else if (rel == len_p1) begin
					tail_ok_d = (b == cfg.tail_first);
				end else begin
					// last tail byte closes the frame
					in_frame_d  = 1'b0;
					count_d     = '0;
					start.valid = 1'b1;
					if (!tail_good) begin
						start.status = sfd_pkg::StBadTail;
					end else if (len_q > 16'(sfd_pkg::MaxPayload)) begin
						start.status = sfd_pkg::StTooLong;
					end else if (!sum_ok_q) begin
						start.status = sfd_pkg::StBadSum;
					end else begin
						start.status = sfd_pkg::StOk;
						start.cnt    = len_q[sfd_pkg::CntW-1:0];
					end
				end
			end
		end else if (fire && link_q) begin
			// millisecond tick while the link is up
			idle_d = idle_inc;
			if (idle_inc > cfg.link_timeout_ms) begin
				link_d        = 1'b0;
				start.valid   = 1'b1;
				start.status  = sfd_pkg::StLinkLost;
				start.control = '0;
				start.command = '0;
				start.length  = '0;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			ctrl_q     <= '0;
			cmd_q      <= '0;
			len_q      <= '0;
			sum_q      <= '0;
			sum_ok_q   <= 1'b0;
			tail_ok_q  <= 1'b0;
			link_q     <= 1'b0;
			idle_q     <= '0;
		end else begin
			in_frame_q <= in_frame_d;
			count_q    <= count_d;
			ctrl_q     <= ctrl_d;
			cmd_q      <= cmd_d;
			len_q      <= len_d;
			sum_q      <= sum_d;
			sum_ok_q   <= sum_ok_d;
			tail_ok_q  <= tail_ok_d;
			link_q     <= link_d;
			idle_q     <= idle_d;
		end
	end

	// Hunting always leaves the position counter cleared
	a_hunt_count: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> count_q == 17'd0)
		else $error("position counter set while hunting");

	// Link loss is only reported from an up link
	a_lost_from_up: assert property (@(posedge clk) disable iff (!arst_n)
		start.valid && start.status == sfd_pkg::StLinkLost |-> link_q)
		else $error("link loss reported while link down");

endmodule

// ----- sv/sfd_emitter.sv -----
// Result sequencer: payload store plus one read port walked once per result
module sfd_emitter (
	input  logic              clk,
	input  logic              arst_n,
	input  sfd_pkg::wr_t      wr,
	input  sfd_pkg::start_t   start,
	output logic              busy,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sfd_pkg::rsp_t     rsp_data
);

	localparam logic [1:0] EmIdle  = 2'd0;
	localparam logic [1:0] EmFetch = 2'd1;
	localparam logic [1:0] EmShow  = 2'd2;

	logic [1:0]                  state_q;
	sfd_pkg::start_t             hdr_q;
	logic [sfd_pkg::CntW-1:0]    cnt_q;
	logic [sfd_pkg::IdxW-1:0]    idx_q;
	logic                        zero_q;
	logic [7:0]                  rd_q;
	logic [7:0]                  mem [sfd_pkg::MaxPayload];

	logic                        last;
	logic                        rd_en;
	logic [sfd_pkg::IdxW-1:0]    rd_addr;
	logic [sfd_pkg::IdxW-1:0]    idx_next;

	assign busy      = (state_q != EmIdle);
	assign rsp_valid = (state_q == EmShow);
	assign idx_next  = idx_q + 1'b1;
	assign last      = zero_q || ({1'b0, idx_q} + 1'b1 == cnt_q);
	assign rd_en     = (state_q == EmFetch)
		|| (state_q == EmShow && !rsp_stall && !last);
	assign rd_addr   = (state_q == EmShow) ? idx_next : idx_q;

	// Result fields
	always_comb begin
		rsp_data.status         = hdr_q.status;
		rsp_data.control_code   = hdr_q.control;
		rsp_data.command_code   = hdr_q.command;
		rsp_data.payload_length = hdr_q.length;
		rsp_data.byte_index     = 5'(idx_q);
		rsp_data.payload_byte   = zero_q ? 8'h00 : rd_q;
		rsp_data.last           = last;
		rsp_data.link_up        = hdr_q.link_up;
	end

	// Payload store, registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EmIdle;
			hdr_q   <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			zero_q  <= 1'b0;
		end else begin
			case (state_q)
				EmIdle: begin
					if (start.valid) begin
						hdr_q  <= start;
						cnt_q  <= start.cnt;
						idx_q  <= '0;
						zero_q <= (start.cnt == '0);
						state_q <= (start.cnt == '0) ? EmShow : EmFetch;
					end
				end
				EmFetch: begin
					state_q <= EmShow;
				end
				EmShow: begin
					if (!rsp_stall) begin
						if (last) begin
							state_q <= EmIdle;
						end else begin
							idx_q <= idx_next;
						end
					end
				end
				default: state_q <= EmIdle;
			endcase
		end
	end

	// A new run never arrives while one is being delivered
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		start.valid |-> !busy)
		else $error("result run launched while busy");

	// Index stays inside the run
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !zero_q |-> {1'b0, idx_q} < cnt_q)
		else $error("payload index beyond run length");

	// The last result closes the run
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && last |=> !rsp_valid)
		else $error("result shown after last");

endmodule

// ----- sv/sensor_frame_deframer.sv -----
// Sensor frame deframer. Each request is a received UART byte or a one
// millisecond tick. A byte or tick is absorbed in the cycle it is accepted.
// A frame's last tail byte, or a tick that exceeds link_timeout_ms, starts
// a result run: one result for an error, an empty payload or a link loss,
// otherwise one result per payload byte (up to 32) with the last marked.
// Results come from a payload store with one write and one read port, walked
// one entry a cycle while rsp_stall is low, so req_stall stays high while a
// run is fetched and shown. Registers are written through the cfg port (always
// ready); the user must write them only while the block is idle, which the
// block itself does not enforce; indexes past the last register are ignored.
module sensor_frame_deframer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  sfd_pkg::req_t     req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sfd_pkg::rsp_t     rsp_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	sfd_pkg::cfg_t   cfg_q;
	sfd_pkg::wr_t    wr;
	sfd_pkg::start_t start;
	logic            busy;
	logic            fire;

	assign cfg_ready = 1'b1;
	assign req_stall = busy;
	assign fire      = req_valid && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first    <= sfd_pkg::RstHeaderFirst;
			cfg_q.header_second   <= sfd_pkg::RstHeaderSecond;
			cfg_q.tail_first      <= sfd_pkg::RstTailFirst;
			cfg_q.tail_second     <= sfd_pkg::RstTailSecond;
			cfg_q.link_timeout_ms <= sfd_pkg::RstLinkTimeout;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfd_pkg::RegHeaderFirst:  cfg_q.header_first    <= cfg_data[7:0];
				sfd_pkg::RegHeaderSecond: cfg_q.header_second   <= cfg_data[7:0];
				sfd_pkg::RegTailFirst:    cfg_q.tail_first      <= cfg_data[7:0];
				sfd_pkg::RegTailSecond:   cfg_q.tail_second     <= cfg_data[7:0];
				sfd_pkg::RegLinkTimeout:  cfg_q.link_timeout_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	sfd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_data),
		.cfg    (cfg_q),
		.wr     (wr),
		.start  (start)
	);

	sfd_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.start     (start),
		.busy      (busy),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

// ----- tb/tb_sensor_frame_deframer.sv -----
module tb_sensor_frame_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 1000000;
	localparam int unsigned ItemTarget = 410;
	localparam logic [2:0] RegUnused = 3'd7;

	// Ways a generated frame can be broken
	typedef enum {
		FlawNone,
		FlawBadSum,
		FlawBadTailFirst,
		FlawBadTailSecond,
		FlawTailAndSum,
		FlawBadHeader
	} flaw_e;

	// Deframer predictor plus the queue of results it expects
	class frame_scoreboard;
		sfd_pkg::cfg_t cfg;
		bit            in_frame;
		int unsigned   byte_count;
		bit [7:0]      frame_control;
		bit [7:0]      frame_command;
		bit [15:0]     frame_length;
		bit [7:0]      running_sum;
		bit            sum_match;
		bit            tail_match;
		bit [7:0]      store [sfd_pkg::MaxPayload];
		bit            link_flag;
		bit [15:0]     idle_ms;
		sfd_pkg::rsp_t expected_q [$];
		int unsigned   mismatches;
		int unsigned   checked;
		int unsigned   frames_ok;
		int unsigned   frame_errors;
		int unsigned   link_losses;

		function new();
			cfg = '{header_first: sfd_pkg::RstHeaderFirst,
				header_second: sfd_pkg::RstHeaderSecond,
				tail_first: sfd_pkg::RstTailFirst, tail_second: sfd_pkg::RstTailSecond,
				link_timeout_ms: sfd_pkg::RstLinkTimeout};
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				sfd_pkg::RegHeaderFirst:  cfg.header_first = val[7:0];
				sfd_pkg::RegHeaderSecond: cfg.header_second = val[7:0];
				sfd_pkg::RegTailFirst:    cfg.tail_first = val[7:0];
				sfd_pkg::RegTailSecond:   cfg.tail_second = val[7:0];
				sfd_pkg::RegLinkTimeout:  cfg.link_timeout_ms = val;
				default: ;
			endcase
		endfunction

		function void push_result(logic [2:0] st, int unsigned idx, bit [7:0] pb, bit last,
			bit with_frame);
			sfd_pkg::rsp_t e;
			e.status         = st;
			e.control_code   = with_frame ? frame_control : 8'h00;
			e.command_code   = with_frame ? frame_command : 8'h00;
			e.payload_length = with_frame ? frame_length : 16'h0000;
			e.byte_index     = idx[4:0];
			e.payload_byte   = pb;
			e.last           = last;
			e.link_up        = link_flag;
			expected_q.push_back(e);
		endfunction

		// Final tail byte: tail first, then length, then checksum
		function void finish_frame(bit [7:0] b);
			in_frame   = 1'b0;
			byte_count = 0;
			if (!(tail_match && b == cfg.tail_second)) begin
				push_result(sfd_pkg::StBadTail, 0, 8'h00, 1'b1, 1'b1);
				frame_errors++;
			end else if (frame_length > sfd_pkg::MaxPayload) begin
				push_result(sfd_pkg::StTooLong, 0, 8'h00, 1'b1, 1'b1);
				frame_errors++;
			end else if (!sum_match) begin
				push_result(sfd_pkg::StBadSum, 0, 8'h00, 1'b1, 1'b1);
				frame_errors++;
			end else if (frame_length == 0) begin
				push_result(sfd_pkg::StOk, 0, 8'h00, 1'b1, 1'b1);
				frames_ok++;
			end else begin
				for (int unsigned i = 0; i < frame_length; i++)
					push_result(sfd_pkg::StOk, i, store[i], (i + 1 == frame_length), 1'b1);
				frames_ok++;
			end
		endfunction

		function void take_byte(bit [7:0] b);
			int unsigned p;
			int unsigned len;
			if (!in_frame) begin
				if (b == cfg.header_first) begin
					in_frame    = 1'b1;
					byte_count  = 1;
					running_sum = b;
				end
				return;
			end
			p = byte_count;
			byte_count++;
			len = 32'(frame_length);
			if (p == 1) begin
				// mismatching byte is not retried as a first header byte
				if (b != cfg.header_second) begin
					in_frame   = 1'b0;
					byte_count = 0;
				end else begin
					running_sum += b;
				end
			end else if (p < 6) begin
				running_sum += b;
				case (p)
					2: frame_control = b;
					3: frame_command = b;
					4: frame_length = {b, 8'h00};
					default: frame_length[7:0] = b;
				endcase
			end else if (p < 6 + len) begin
				// over-long payload is counted but not stored
				running_sum += b;
				if (p - 6 < sfd_pkg::MaxPayload)
					store[p - 6] = b;
			end else if (p == 6 + len) begin
				sum_match = (b == running_sum);
			end else if (p == 7 + len) begin
				tail_match = (b == cfg.tail_first);
			end else begin
				finish_frame(b);
			end
		endfunction

		function void note_req(sfd_pkg::req_t r);
			if (r.req_type == sfd_pkg::ReqByte) begin
				idle_ms   = 16'h0000;
				link_flag = 1'b1;
				take_byte(r.rx_byte);
			end else if (link_flag) begin
				if (idle_ms != 16'hFFFF)
					idle_ms++;
				if (idle_ms > cfg.link_timeout_ms) begin
					link_flag = 1'b0;
					push_result(sfd_pkg::StLinkLost, 0, 8'h00, 1'b1, 1'b0);
					link_losses++;
				end
			end
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			mismatches++;
		endtask

		task check_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
					checked, name, got, want));
		endtask

		task check_rsp(sfd_pkg::rsp_t got);
			sfd_pkg::rsp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result 0x%0h", got));
				return;
			end
			want = expected_q.pop_front();
			check_field("status", 16'(got.status), 16'(want.status));
			check_field("control_code", 16'(got.control_code), 16'(want.control_code));
			check_field("command_code", 16'(got.command_code), 16'(want.command_code));
			check_field("payload_length", got.payload_length, want.payload_length);
			check_field("byte_index", 16'(got.byte_index), 16'(want.byte_index));
			check_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
			check_field("last", 16'(got.last), 16'(want.last));
			check_field("link_up", 16'(got.link_up), 16'(want.link_up));
			checked++;
		endtask
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	sfd_pkg::req_t req_data = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	sfd_pkg::rsp_t rsp_data;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [2:0]    cfg_index = '0;
	logic [15:0]   cfg_data = '0;

	frame_scoreboard sb = new();
	sfd_pkg::req_t   stim_q [$];
	bit              no_gaps;
	int unsigned     tick_pct;
	int unsigned     stall_left;
	int unsigned     cycles;
	int unsigned     items_sent;

	sensor_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				sb.expected_q.size());
			$display("tb_sensor_frame_deframer: FAIL");
			$finish;
		end
	end

	function automatic int unsigned draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 12);
	endfunction

	// Result side: check each accepted result, then stall a random while
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_rsp(rsp_data);
			stall_left = draw_gap();
			rsp_stall <= (stall_left != 0);
		end else if (stall_left != 0) begin
			stall_left--;
			rsp_stall <= (stall_left != 0);
		end else if (!no_gaps && $urandom_range(0, 15) == 0) begin
			stall_left = $urandom_range(1, 12);
			rsp_stall <= 1'b1;
		end
	end

	task automatic add_byte(logic [7:0] b);
		stim_q.push_back('{req_type: sfd_pkg::ReqByte, rx_byte: b});
	endtask

	task automatic add_tick();
		stim_q.push_back('{req_type: sfd_pkg::ReqTick, rx_byte: 8'($urandom)});
	endtask

	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == sb.cfg.header_first);
		return b;
	endfunction

	// Queue one frame under the current header and tail settings
	task automatic add_frame(logic [7:0] ctrl, logic [7:0] cmd, int unsigned len, flaw_e flaw);
		logic [7:0]  bytes [$];
		logic [7:0]  sum;
		logic [7:0]  b;
		logic [15:0] length;
		length = 16'(len);
		bytes.push_back(sb.cfg.header_first);
		if (flaw == FlawBadHeader) begin
			b = $urandom_range(0, 1) ? sb.cfg.header_first : 8'($urandom);
			if (b == sb.cfg.header_second)
				b = b ^ 8'h01;
			bytes.push_back(b);
		end else begin
			bytes.push_back(sb.cfg.header_second);
			bytes.push_back(ctrl);
			bytes.push_back(cmd);
			bytes.push_back(length[15:8]);
			bytes.push_back(length[7:0]);
			repeat (len) bytes.push_back(8'($urandom));
			sum = '0;
			foreach (bytes[i])
				sum += bytes[i];
			if (flaw == FlawBadSum || flaw == FlawTailAndSum)
				sum ^= 8'($urandom_range(1, 255));
			bytes.push_back(sum);
			b = sb.cfg.tail_first;
			if (flaw == FlawBadTailFirst || flaw == FlawTailAndSum)
				b ^= 8'($urandom_range(1, 255));
			bytes.push_back(b);
			b = sb.cfg.tail_second;
			if (flaw == FlawBadTailSecond)
				b ^= 8'($urandom_range(1, 255));
			bytes.push_back(b);
		end
		foreach (bytes[i]) begin
			if ($urandom_range(0, 99) < tick_pct)
				repeat ($urandom_range(1, 3)) add_tick();
			add_byte(bytes[i]);
		end
	endtask

	// Send every queued request, idling a random number of cycles before each
	task automatic send_all();
		sfd_pkg::req_t r;
		int unsigned   gap;
		while (stim_q.size() != 0) begin
			r = stim_q.pop_front();
			if ($urandom_range(0, 29) == 0)
				no_gaps = !no_gaps;
			gap = draw_gap();
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			req_valid <= 1'b1;
			req_data  <= r;
			do @(posedge clk); while (req_stall);
			sb.note_req(r);
			items_sent++;
		end
		req_valid <= 1'b0;
	endtask

	// Wait until every expected result is in and the block has gone quiet
	task automatic settle();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(logic [7:0] h1, logic [7:0] h2, logic [7:0] t1, logic [7:0] t2,
		logic [15:0] tmo);
		logic [2:0]  regs [6];
		logic [15:0] vals [6];
		regs = '{sfd_pkg::RegHeaderFirst, sfd_pkg::RegHeaderSecond, sfd_pkg::RegTailFirst,
			sfd_pkg::RegTailSecond, sfd_pkg::RegLinkTimeout, RegUnused};
		vals = '{16'(h1), 16'(h2), 16'(t1), 16'(t2), tmo, 16'($urandom)};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase();
		logic [15:0] tmo;
		int unsigned target;
		int unsigned pick;
		flaw_e       flaw;
		case ($urandom_range(0, 5))
			0: tmo = 16'd1;
			1: tmo = 16'd2;
			2: tmo = 16'd3;
			3: tmo = 16'($urandom_range(4, 40));
			4: tmo = 16'hFFFF;
			default: tmo = sfd_pkg::RstLinkTimeout;
		endcase
		set_config($urandom_range(0, 1) ? sfd_pkg::RstHeaderFirst : 8'($urandom),
			$urandom_range(0, 1) ? sfd_pkg::RstHeaderSecond : 8'($urandom),
			$urandom_range(0, 1) ? sfd_pkg::RstTailFirst : 8'($urandom),
			$urandom_range(0, 1) ? sfd_pkg::RstTailSecond : 8'($urandom), tmo);
		tick_pct = $urandom_range(0, 15);
		target   = $urandom_range(15, 40);
		// mostly well-formed frames, some broken ones, noise and idle ticks
		while (stim_q.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				if ($urandom_range(0, 99) < 80)
					flaw = FlawNone;
				else
					flaw = flaw_e'($urandom_range(FlawBadSum, FlawBadHeader));
				pick = $urandom_range(0, 99);
				add_frame(8'($urandom), 8'($urandom),
					pick < 70 ? $urandom_range(0, 12) :
					pick < 92 ? $urandom_range(13, sfd_pkg::MaxPayload) :
					$urandom_range(sfd_pkg::MaxPayload + 1, 45), flaw);
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 4)) add_byte(noise_byte());
			end else begin
				repeat ($urandom_range(1, 5)) add_tick();
			end
		end
		send_all();
		settle();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: ticks with link down, good frames, every rejection
		tick_pct = 0;
		add_tick();
		add_tick();
		add_frame(8'h00, 8'hFF, 0, FlawNone);
		add_frame(8'hFF, 8'h00, 1, FlawNone);
		// repeated first header byte does not restart the hunt
		add_byte(sfd_pkg::RstHeaderFirst);
		add_byte(sfd_pkg::RstHeaderFirst);
		add_byte(sfd_pkg::RstHeaderSecond);
		add_frame(8'h5A, 8'hA5, 3, FlawNone);
		add_frame(8'h01, 8'h02, 2, FlawBadTailFirst);
		add_frame(8'h03, 8'h04, 2, FlawBadTailSecond);
		add_frame(8'h05, 8'h06, 4, FlawBadSum);
		add_frame(8'h07, 8'h08, 2, FlawTailAndSum);
		add_frame(8'h09, 8'h0A, sfd_pkg::MaxPayload + 1, FlawBadSum);
		add_frame(8'h0B, 8'h0C, 40, FlawBadTailFirst);
		send_all();
		settle();

		// Extreme settings, quickest link loss, loss inside a frame
		set_config(8'h00, 8'hFF, 8'hFF, 8'h00, 16'd1);
		add_frame(8'hFF, 8'hFF, sfd_pkg::MaxPayload, FlawNone);
		add_tick();
		add_tick();
		add_tick();
		tick_pct = 100;
		add_frame(8'h11, 8'h22, 2, FlawNone);
		tick_pct = 0;
		add_frame(8'h33, 8'h44, sfd_pkg::MaxPayload + 4, FlawNone);
		send_all();
		settle();

		// Slowest timeout never fires
		set_config(8'hFF, 8'h00, 8'h00, 8'hFF, 16'hFFFF);
		add_frame(8'h80, 8'h7F, 5, FlawNone);
		repeat (40) add_tick();
		add_frame(8'h00, 8'h00, 0, FlawNone);
		send_all();
		settle();

		while (items_sent < ItemTarget)
			random_phase();

		repeat (20) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));
		$display("Sent %0d requests over several header/tail/timeout settings; checked %0d results",
			items_sent, sb.checked);
		$display("Frames: %0d delivered, %0d rejected; link lost %0d times; %0d mismatches",
			sb.frames_ok, sb.frame_errors, sb.link_losses, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("tb_sensor_frame_deframer: PASS");
		end else begin
			$display("tb_sensor_frame_deframer: FAIL");
		end
		$finish;
	end

endmodule
